>>> src/bpagc_pkg.sv
package bpagc_pkg;

   // result field widths
   localparam int GAIN_W = 24;

   // gain constants, signed Q8.16
   localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 24'sd65536;
   localparam logic signed [GAIN_W-1:0] GAIN_MAX   = 24'sh7FFFFF;
   localparam logic signed [GAIN_W-1:0] GAIN_MIN   = 24'sh800000;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LEVEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DIVISOR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNITY_FLOOR   = 3'd4;

   // register widths
   localparam int TARGET_W = 16;
   localparam int COUNT_W  = 5;
   localparam int STEPDIV_W = 11;

   // register reset values
   localparam logic                       ENABLE_RST   = 1'b1;
   localparam logic signed [TARGET_W-1:0] TARGET_RST   = 16'sd16384;
   localparam logic [COUNT_W-1:0]         COUNT_RST    = 5'd16;
   localparam logic [STEPDIV_W-1:0]       STEPDIV_RST  = 11'd4;
   localparam logic                       UNITY_RST    = 1'b0;
   localparam logic [STEPDIV_W-1:0]       STEPDIV_MAX  = 11'd1024;

   // gain update sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MEAN,
      ST_NEED,
      ST_DIFF,
      ST_STEP
   } agc_state_type;

endpackage

>>> src/bpagc_req_if.sv
interface bpagc_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_in_block;

   modport source (output valid, sample, last_in_block, input ready);
   modport sink   (input valid, sample, last_in_block, output ready);
endinterface

>>> src/bpagc_rsp_if.sv
interface bpagc_rsp_if #(parameter int SAMPLE_BITS = 16);
   import bpagc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [GAIN_W-1:0]      gain;
   logic                          gain_updated;
   logic signed [SAMPLE_BITS-1:0] block_peak;

   modport source (output valid, gain, gain_updated, block_peak, input ready);
   modport sink   (input valid, gain, gain_updated, block_peak, output ready);
endinterface

>>> src/bpagc_ram.sv
module bpagc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/bpagc_div.sv
module bpagc_div #(
   parameter int DVW = 37,
   parameter int DSW = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           done,
   output logic [DVW-1:0] quotient
);
   localparam int CNT_W = $clog2(DVW + 1);

   logic [DVW-1:0]   quo_ff;
   logic [DSW-1:0]   rem_ff;
   logic [DSW-1:0]   rem_in;
   logic [DSW-1:0]   dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DSW:0]     trial;
   logic             fits;

   // restoring step: one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[DVW-1]};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? DSW'(trial - {1'b0, dsr_ff}) : trial[DSW-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVW-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> src/block_peak_agc_gain.sv
// Block-peak automatic gain control.
// Samples come in on req_chan, each with a last-of-block flag; the block keeps
// the largest sample of the current block. Every block end gives one item on
// rsp_chan: the gain (signed Q8.16), an update flag and the block peak.
// While enabled, each block peak goes into a ring of the last average_count
// peaks, and every average_count+1 block ends the ring mean sets a new gain.
// The csr_ port writes one register per cycle; write it only while idle.
// Samples that do not end a block are accepted whenever the sequencer is idle
// and the result register is free. A block end without a gain update gives its
// item on the next cycle. A block end with an update runs the ring sum over
// the RAM read port and then up to three divisions on one shared bit-serial
// divider, during which req_chan.ready is low. A zero mean ends after the
// first division, and the unity floor skips the third one when the needed
// gain is below unity.
// Reset clears the ring (per-entry valid bits), the gain to unity and the
// configuration registers to their defaults. A stalled receiver holds the
// result register; req_chan.ready stays low for every sample until it is taken.
module block_peak_agc_gain #(
   parameter int SAMPLE_BITS = 16,
   parameter int PEAK_DEPTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   bpagc_req_if.sink                           req_chan,
   bpagc_rsp_if.source                         rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [bpagc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpagc_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import bpagc_pkg::*;

   localparam int SW     = SAMPLE_BITS + COUNT_W;
   localparam int DVW    = (SW > 32) ? SW : 32;
   localparam int DSW    = (SAMPLE_BITS > STEPDIV_W) ? SAMPLE_BITS : STEPDIV_W;
   localparam int AW     = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
   localparam int CMP_W  = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
   localparam int DIFF_W = GAIN_W + 1;
   localparam int STEP_W = GAIN_W + 2;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // configuration registers
   logic                       enable_ff;
   logic signed [TARGET_W-1:0] target_ff;
   logic [COUNT_W-1:0]         avg_ff;
   logic [STEPDIV_W-1:0]       stepdiv_ff;
   logic                       unity_ff;

   // block tracking and ring control
   logic signed [SAMPLE_BITS-1:0] running_ff;
   logic                          block_start_ff;
   logic [AW-1:0]                 ptr_ff;
   logic [COUNT_W-1:0]            hold_ff;
   logic [PEAK_DEPTH-1:0]         valid_ff;
   logic                          rd_valid_ff;

   // sequencer and datapath
   agc_state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]            idx_ff;
   logic                          pend_ff;
   logic signed [SW-1:0]          sum_ff;
   logic signed [GAIN_W-1:0]      gain_ff, gain_in;
   logic signed [GAIN_W-1:0]      needed_ff, needed_in;
   logic                          diff_neg_ff;
   logic signed [SAMPLE_BITS-1:0] peak_hold_ff;

   // result register
   logic                          rsp_valid_ff;
   logic signed [GAIN_W-1:0]      rsp_gain_ff;
   logic                          rsp_upd_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_peak_ff;

   logic                          req_ready;
   logic                          accept;
   logic                          last_acc;
   logic                          slot_free;
   logic signed [SAMPLE_BITS-1:0] peak_now;
   logic [COUNT_W-1:0]            n_eff;
   logic [STEPDIV_W-1:0]          d_eff;
   logic [CMP_W-1:0]              ptr_plus;
   logic [COUNT_W-1:0]            hold_next;
   logic                          upd_due;
   logic [SAMPLE_BITS-1:0]        ram_q;
   logic signed [SAMPLE_BITS-1:0] entry;
   logic [SW-1:0]                 sum_mag;
   logic [TARGET_W-1:0]           tgt_mag;
   logic signed [DIFF_W-1:0]      diff;
   logic [DIFF_W-1:0]             diff_mag;
   logic signed [STEP_W-1:0]      step;
   logic signed [STEP_W-1:0]      gain_sum;
   logic                          need_neg;

   logic                          div_start;
   logic [DVW-1:0]                div_dividend;
   logic [DSW-1:0]                div_divisor;
   logic                          div_done;
   logic [DVW-1:0]                div_quo;

   logic                          emit;
   logic                          emit_upd;
   logic                          idx_issue;

   // handshake
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready      = (state_ff == ST_IDLE) && slot_free;
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;
   assign last_acc       = accept && req_chan.last_in_block;

   // running peak including the sample at the port
   assign peak_now = (block_start_ff || (req_chan.sample > running_ff)) ?
                     req_chan.sample : running_ff;

   // effective count and divisor
   always_comb begin
      if (avg_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (32'(avg_ff) > PEAK_DEPTH) begin
         n_eff = COUNT_W'(PEAK_DEPTH);
      end else begin
         n_eff = avg_ff;
      end
      if (stepdiv_ff == '0) begin
         d_eff = STEPDIV_W'(1);
      end else if (stepdiv_ff > STEPDIV_MAX) begin
         d_eff = STEPDIV_MAX;
      end else begin
         d_eff = stepdiv_ff;
      end
   end

   // ring pointer and hold counter advance
   assign ptr_plus  = CMP_W'(ptr_ff) + CMP_W'(1);
   assign hold_next = hold_ff + COUNT_W'(1);
   assign upd_due   = (hold_next > n_eff) || (hold_next == '0);

   // peak ring
   bpagc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (PEAK_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (last_acc && enable_ff),
      .wr_addr (ptr_ff),
      .wr_data (peak_now),
      .rd_addr (AW'(idx_ff)),
      .rd_data (ram_q)
   );

   // entries never written read as zero
   assign entry = rd_valid_ff ? $signed(ram_q) : '0;

   // magnitudes for the unsigned divider
   assign sum_mag  = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign tgt_mag  = target_ff[TARGET_W-1] ? TARGET_W'(-target_ff) : TARGET_W'(target_ff);
   assign diff     = {needed_ff[GAIN_W-1], needed_ff} - {gain_ff[GAIN_W-1], gain_ff};
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign need_neg = target_ff[TARGET_W-1] ^ sum_ff[SW-1];

   // saturated needed gain from the second division
   always_comb begin
      if (!need_neg) begin
         if (div_quo > DVW'(GAIN_MAX)) begin
            needed_in = GAIN_MAX;
         end else begin
            needed_in = div_quo[GAIN_W-1:0];
         end
      end else begin
         if (div_quo > {{(DVW-GAIN_W){1'b0}}, GAIN_MIN}) begin
            needed_in = GAIN_MIN;
         end else begin
            needed_in = -$signed(div_quo[GAIN_W-1:0]);
         end
      end
   end

   // gain step from the third division, saturated
   always_comb begin
      step = diff_neg_ff ? -$signed({1'b0, div_quo[DIFF_W-1:0]})
                         : $signed({1'b0, div_quo[DIFF_W-1:0]});
      gain_sum = STEP_W'(gain_ff) + step;
      if (gain_sum > STEP_W'(GAIN_MAX)) begin
         gain_in = GAIN_MAX;
      end else if (gain_sum < STEP_W'(GAIN_MIN)) begin
         gain_in = GAIN_MIN;
      end else begin
         gain_in = gain_sum[GAIN_W-1:0];
      end
   end

   // divider operand select
   always_comb begin
      case (state_ff)
         ST_SUM: begin
            div_dividend = DVW'(sum_mag);
            div_divisor  = DSW'(n_eff);
         end
         ST_MEAN: begin
            div_dividend = DVW'({tgt_mag, 16'b0});
            div_divisor  = DSW'(div_quo[SAMPLE_BITS-1:0]);
         end
         default: begin
            div_dividend = DVW'(diff_mag);
            div_divisor  = DSW'(d_eff);
         end
      endcase
   end

   bpagc_div #(
      .DVW (DVW),
      .DSW (DSW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // sequencer next state and strobes
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      emit      = 1'b0;
      emit_upd  = 1'b0;
      idx_issue = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (last_acc) begin
               if (enable_ff && upd_due) begin
                  state_in = ST_SUM;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         ST_SUM: begin
            idx_issue = (idx_ff < n_eff);
            if (!idx_issue && !pend_ff) begin
               div_start = 1'b1;
               state_in  = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_done) begin
               if (div_quo == '0) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_NEED;
               end
            end
         end
         ST_NEED: begin
            if (div_done) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (unity_ff && (needed_ff < GAIN_UNITY)) begin
               emit     = 1'b1;
               emit_upd = 1'b1;
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            if (div_done) begin
               emit     = 1'b1;
               emit_upd = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         enable_ff      <= ENABLE_RST;
         target_ff      <= TARGET_RST;
         avg_ff         <= COUNT_RST;
         stepdiv_ff     <= STEPDIV_RST;
         unity_ff       <= UNITY_RST;
         running_ff     <= SAMPLE_MIN;
         block_start_ff <= 1'b1;
         ptr_ff         <= '0;
         hold_ff        <= '0;
         valid_ff       <= '0;
         gain_ff        <= GAIN_UNITY;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
         idx_ff         <= '0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLE:        enable_ff  <= csr_wr_data[0];
               CSR_TARGET_LEVEL:  target_ff  <= $signed(csr_wr_data[TARGET_W-1:0]);
               CSR_AVERAGE_COUNT: avg_ff     <= csr_wr_data[COUNT_W-1:0];
               CSR_STEP_DIVISOR:  stepdiv_ff <= csr_wr_data[STEPDIV_W-1:0];
               CSR_UNITY_FLOOR:   unity_ff   <= csr_wr_data[0];
               default: begin
               end
            endcase
         end

         // block peak tracking
         if (accept) begin
            if (req_chan.last_in_block) begin
               running_ff     <= SAMPLE_MIN;
               block_start_ff <= 1'b1;
            end else begin
               running_ff     <= peak_now;
               block_start_ff <= 1'b0;
            end
         end

         // ring pointer, hold count, valid bits
         if (last_acc && enable_ff) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff <= (ptr_plus >= CMP_W'(n_eff)) ? '0 : AW'(ptr_plus);
            hold_ff <= upd_due ? '0 : hold_next;
         end

         // ring sum read sequence
         if (state_ff == ST_IDLE) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (state_ff == ST_SUM) begin
            pend_ff <= idx_issue;
            if (idx_issue) begin
               idx_ff <= idx_ff + COUNT_W'(1);
            end
         end

         // gain update
         if (state_ff == ST_DIFF && state_in == ST_IDLE) begin
            gain_ff <= GAIN_UNITY;
         end else if (state_ff == ST_STEP && div_done) begin
            gain_ff <= gain_in;
         end

         // result register
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[AW'(idx_ff)];

      if (state_ff == ST_IDLE) begin
         sum_ff <= '0;
      end else if (state_ff == ST_SUM && pend_ff) begin
         sum_ff <= sum_ff + SW'(entry);
      end

      if (last_acc) begin
         peak_hold_ff <= peak_now;
      end

      if (state_ff == ST_NEED && div_done) begin
         needed_ff <= needed_in;
      end

      if (state_ff == ST_DIFF) begin
         diff_neg_ff <= diff[DIFF_W-1];
      end

      // result payload
      if (emit) begin
         rsp_upd_ff <= emit_upd;
         if (state_ff == ST_IDLE) begin
            rsp_gain_ff <= gain_ff;
            rsp_peak_ff <= peak_now;
         end else begin
            rsp_peak_ff <= peak_hold_ff;
            if (state_ff == ST_DIFF) begin
               rsp_gain_ff <= GAIN_UNITY;
            end else if (state_ff == ST_STEP) begin
               rsp_gain_ff <= gain_in;
            end else begin
               rsp_gain_ff <= gain_ff;
            end
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.gain         = rsp_gain_ff;
   assign rsp_chan.gain_updated = rsp_upd_ff;
   assign rsp_chan.block_peak   = rsp_peak_ff;
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bpagc_pkg::*;

   localparam int SAMPLE_BITS = 16;

   // one block-end item as the block should report it
   typedef struct {
      logic signed [GAIN_W-1:0]      gain;
      logic                          gain_updated;
      logic signed [SAMPLE_BITS-1:0] block_peak;
   } block_end_type;

   // tracks block peaks and the gain, queues the item due at every block end
   class gain_tracker;
      logic signed [SAMPLE_BITS-1:0] peak_hist[16];
      logic [3:0]                    hist_ptr;
      logic [4:0]                    ends_since_update;
      logic signed [SAMPLE_BITS-1:0] blk_peak;
      bit                            blk_open;
      logic signed [GAIN_W-1:0]      gain_q;

      bit                            agc_on;
      logic signed [TARGET_W-1:0]    target;
      logic [COUNT_W-1:0]            avg_n;
      logic [STEPDIV_W-1:0]          step_div;
      bit                            floor_unity;

      block_end_type                 block_end_queue[$];
      int                            mismatch_count;

      function new();
         foreach (peak_hist[i]) peak_hist[i] = '0;
         hist_ptr          = '0;
         ends_since_update = '0;
         blk_peak          = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         blk_open          = 1'b1;
         gain_q            = GAIN_UNITY;
         agc_on            = ENABLE_RST;
         target            = TARGET_RST;
         avg_n             = COUNT_RST;
         step_div          = STEPDIV_RST;
         floor_unity       = UNITY_RST;
         mismatch_count    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ENABLE:        agc_on      = data[0];
            CSR_TARGET_LEVEL:  target      = data[TARGET_W-1:0];
            CSR_AVERAGE_COUNT: avg_n       = data[COUNT_W-1:0];
            CSR_STEP_DIVISOR:  step_div    = data[STEPDIV_W-1:0];
            CSR_UNITY_FLOOR:   floor_unity = data[0];
            default: ;
         endcase
      endfunction

      function int peaks_used();
         if (avg_n < 1) return 1;
         if (avg_n > 16) return 16;
         return int'(avg_n);
      endfunction

      function logic signed [GAIN_W-1:0] clip_gain(longint v);
         if (v > longint'(GAIN_MAX)) return GAIN_MAX;
         if (v < longint'(GAIN_MIN)) return GAIN_MIN;
         return v[GAIN_W-1:0];
      endfunction

      // mean of the ring sets the needed gain; gain steps toward it
      function bit recompute_gain();
         int     n;
         longint d;
         longint sum;
         longint mean;
         longint needed;
         n = peaks_used();
         d = (step_div < 1) ? 1 : (step_div > STEPDIV_MAX) ? longint'(STEPDIV_MAX)
                                                           : longint'(step_div);
         sum = 0;
         for (int i = 0; i < n; i++) sum += peak_hist[i];
         mean = sum / longint'(n);
         if (mean == 0) return 1'b0;
         needed = clip_gain((longint'(target) * 65536) / mean);
         if (floor_unity && needed < longint'(GAIN_UNITY))
            gain_q = GAIN_UNITY;
         else
            gain_q = clip_gain(longint'(gain_q) + (needed - longint'(gain_q)) / d);
         return 1'b1;
      endfunction

      function void take_sample(logic signed [SAMPLE_BITS-1:0] s, logic last);
         int            n;
         int            nxt;
         bit            upd;
         block_end_type item;
         if (blk_open || s > blk_peak) blk_peak = s;
         blk_open = 1'b0;
         if (!last) return;
         n   = peaks_used();
         upd = 1'b0;
         // ring and hold count only move while adapting
         if (agc_on) begin
            peak_hist[hist_ptr] = blk_peak;
            nxt = int'(hist_ptr) + 1;
            hist_ptr = (nxt >= n) ? 4'd0 : nxt[3:0];
            ends_since_update = ends_since_update + 5'd1;
            if (ends_since_update > n || ends_since_update == 0) begin
               ends_since_update = '0;
               upd = recompute_gain();
            end
         end
         item.gain         = gain_q;
         item.gain_updated = upd;
         item.block_peak   = blk_peak;
         block_end_queue.push_back(item);
         blk_peak = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         blk_open = 1'b1;
      endfunction

      function void match_block_end(logic signed [GAIN_W-1:0] gain, logic upd,
                                    logic signed [SAMPLE_BITS-1:0] peak);
         block_end_type want;
         if (block_end_queue.size() == 0) begin
            $display("%0t: unexpected item gain %0d updated %0b peak %0d",
                     $realtime, gain, upd, peak);
            mismatch_count++;
            return;
         end
         want = block_end_queue.pop_front();
         if (want.gain !== gain) begin
            $display("%0t: gain expected %0d actual %0d", $realtime, want.gain, gain);
            mismatch_count++;
         end
         if (want.gain_updated !== upd) begin
            $display("%0t: gain_updated expected %0b actual %0b",
                     $realtime, want.gain_updated, upd);
            mismatch_count++;
         end
         if (want.block_peak !== peak) begin
            $display("%0t: block_peak expected %0d actual %0d",
                     $realtime, want.block_peak, peak);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   logic                  rsp_ready_q = 1'b0;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   gain_tracker           sb;

   bpagc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req ();
   bpagc_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp ();

   assign rsp.ready = rsp_ready_q;

   block_peak_agc_gain #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .PEAK_DEPTH (16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready_q <= ($urandom_range(99) >= stall_pct);
   end

   // watch both channels at every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.take_sample(req.sample, req.last_in_block);
         if (rsp.valid && rsp.ready)
            sb.match_block_end(rsp.gain, rsp.gain_updated, rsp.block_peak);
      end
   end

   // one sample, with random idle cycles ahead of it
   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.sample        <= s;
      req.last_in_block <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // stop sending until every block end is back, then let the block go quiet
   task automatic settle(input int extra);
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.block_end_queue.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic configure(input logic en, input int target, input int count,
                            input int div, input logic unity);
      set_reg(CSR_ENABLE, CSR_DATA_W'(en));
      set_reg(CSR_TARGET_LEVEL, CSR_DATA_W'(target));
      set_reg(CSR_AVERAGE_COUNT, CSR_DATA_W'(count));
      set_reg(CSR_STEP_DIVISOR, CSR_DATA_W'(div));
      set_reg(CSR_UNITY_FLOOR, CSR_DATA_W'(unity));
      csr_wr_en <= 1'b0;
   endtask

   // half moderate positive levels, a quarter extremes, a quarter full-range noise
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return SAMPLE_BITS'($urandom);
         default: return SAMPLE_BITS'($urandom_range(30000));
      endcase
   endfunction

   // random blocks, mostly short so that gain updates come often
   task automatic random_phase(input int n_items, input int send_pct, input int stall_pct_v);
      int sent;
      int len;
      int pause_after;
      bit paused;
      send_idle_pct = send_pct;
      stall_pct     = stall_pct_v;
      sent          = 0;
      paused        = 1'b0;
      pause_after   = $urandom_range(n_items - 1);
      while (sent < n_items) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: len = 1;
            5, 6, 7, 8:    len = $urandom_range(6, 2);
            default:       len = $urandom_range(24, 7);
         endcase
         for (int k = 0; k < len; k++) push_sample(pick_sample(), k == len - 1);
         sent += len;
         if (!paused && sent >= pause_after) begin
            settle(0);
            paused = 1'b1;
         end
      end
      settle(200);
   endtask

   int send_mix[4]  = '{0, 68, 0, 21};
   int stall_mix[4] = '{0, 0, 68, 21};

   initial begin
      sb = new();
      reset             <= 1'b1;
      req.valid         <= 1'b0;
      req.sample        <= '0;
      req.last_in_block <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_ENABLE;
      csr_wr_data       <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-peak averaging: zero mean, negative gain, saturation, multi-sample block
      configure(1'b1, 16384, 1, 1, 1'b0);
      push_sample(16'sd0, 1'b1);
      push_sample(16'sd0, 1'b1);
      push_sample(16'sh8000, 1'b1);
      push_sample(16'sh8000, 1'b1);
      push_sample(16'sd1, 1'b1);
      push_sample(16'sd1, 1'b1);
      push_sample(-16'sd5, 1'b0);
      push_sample(16'sd100, 1'b0);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sd7, 1'b1);
      push_sample(16'sh7FFF, 1'b1);
      settle(200);

      // count and divisor of zero, unity floor, most negative target
      configure(1'b1, -32768, 0, 0, 1'b1);
      push_sample(16'sh7FFF, 1'b1);
      push_sample(16'sh7FFF, 1'b1);
      push_sample(-16'sd1, 1'b1);
      push_sample(-16'sd1, 1'b1);
      settle(200);

      // frozen gain, registers above their range
      configure(1'b0, 32767, 31, 2047, 1'b0);
      push_sample(16'sd200, 1'b1);
      push_sample(-16'sd200, 1'b1);
      settle(200);

      // random phases over several settings and idling mixes
      configure(1'b1, 16384, 2, 1, 1'b0);
      random_phase(60, 0, 0);
      configure(1'b1, 32767, 16, 1024, 1'b1);
      random_phase(60, 68, 0);
      configure(1'b1, -32768, 4, 3, 1'b0);
      random_phase(60, 0, 68);
      configure(1'b1, 1000, 1, 1, 1'b0);
      random_phase(60, 21, 21);
      configure(1'b0, $urandom_range(65535), $urandom_range(31), $urandom_range(2047),
                1'($urandom));
      random_phase(40, 68, 0);
      for (int p = 0; p < 4; p++) begin
         configure(1'b1, $urandom_range(65535),
                   ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(4, 1),
                   ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(8, 1),
                   1'($urandom));
         random_phase(45, send_mix[p], stall_mix[p]);
      end

      if (sb.mismatch_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // hard stop
   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
